// ===== src/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PAD_NONE,
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN,
    PAD_DONE
  } pad_t;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam logic [0:7][31:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small0(input logic [31:0] x);
    small0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small1(input logic [31:0] x);
    small1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== src/sha256_hash_core_top.sv =====
// a byte is absorbed while the core is idle; every 64th byte (padding included) starts
// a compression in the shared round unit and a fold step, and the input stalls meanwhile
// closing a message writes 9 to 72 padding and length bytes, with a pad step that writes
// nothing at the length slot, then their compressions, then 8 digest words, held while
// out_stall is high; synchronous reset loads the initial hash and empties the block,
// with no clearing pass; the input is stalled while reset is high
`default_nettype none

module sha256_hash_core_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic             digest_last
);

  sha_pkg::state_t state, state_next;
  sha_pkg::pad_t   pad_step, pad_step_next;

  logic [511:0]     blk;
  logic [5:0]       fill;
  logic [63:0]      bit_length;
  logic [7:0][31:0] vars;
  logic [7:0][31:0] hash;
  logic [5:0]       round;
  logic [2:0]       cnt;
  logic             out_valid_next;

  logic        take;
  logic        put_en;
  logic [7:0]  put_data;
  logic        len_put;
  logic        block_full;
  logic        emit_load;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] ch, maj, t1, t2;

  assign in_stall = rst || (state != sha_pkg::ST_IDLE);
  assign take = in_valid && !in_stall;
  assign block_full = put_en && (fill == sha_pkg::LAST_POS);

  // outputs of the sequencer
  always_comb begin
    put_en = 1'b0;
    put_data = '0;
    len_put = 1'b0;
    emit_load = 1'b0;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (take && has_byte) begin
          put_en = 1'b1;
          put_data = data_byte;
        end
      end
      sha_pkg::ST_PAD: begin
        unique case (pad_step)
          sha_pkg::PAD_MARK: begin
            put_en = 1'b1;
            put_data = sha_pkg::PAD_MARK_BYTE;
          end
          sha_pkg::PAD_ZERO: begin
            put_en = (fill != sha_pkg::LEN_POS);
          end
          sha_pkg::PAD_LEN: begin
            put_en = 1'b1;
            len_put = 1'b1;
            put_data = bit_length[63:56];
          end
          default: ;
        endcase
      end
      sha_pkg::ST_EMIT: begin
        emit_load = !out_valid || !out_stall;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    pad_step_next = pad_step;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (take) begin
          if (end_of_message) begin
            pad_step_next = sha_pkg::PAD_MARK;
          end
          if (block_full) begin
            state_next = sha_pkg::ST_ROUND;
          end else if (end_of_message) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        unique case (pad_step)
          sha_pkg::PAD_MARK: pad_step_next = sha_pkg::PAD_ZERO;
          sha_pkg::PAD_ZERO: begin
            if (fill == sha_pkg::LEN_POS) begin
              pad_step_next = sha_pkg::PAD_LEN;
            end
          end
          sha_pkg::PAD_LEN: begin
            if (cnt == sha_pkg::LAST_WORD) begin
              pad_step_next = sha_pkg::PAD_DONE;
            end
          end
          default: ;
        endcase
        if (block_full) begin
          state_next = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: begin
        if (round == sha_pkg::LAST_ROUND) begin
          state_next = sha_pkg::ST_FOLD;
        end
      end
      sha_pkg::ST_FOLD: begin
        priority case (pad_step)
          sha_pkg::PAD_NONE: state_next = sha_pkg::ST_IDLE;
          sha_pkg::PAD_DONE: state_next = sha_pkg::ST_EMIT;
          default:           state_next = sha_pkg::ST_PAD;
        endcase
      end
      sha_pkg::ST_EMIT: begin
        if (emit_load && (cnt == sha_pkg::LAST_WORD)) begin
          state_next = sha_pkg::ST_IDLE;
          pad_step_next = sha_pkg::PAD_NONE;
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (emit_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // round unit and message schedule
  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];
  assign w_new = sha_pkg::small1(w14) + w9 + sha_pkg::small0(w1) + w0;

  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[1] & vars[2]) ^ (vars[2] & vars[0]);
  assign t1  = vars[7] + sha_pkg::big1(vars[4]) + ch + sha_pkg::ROUND_K[round] + w0;
  assign t2  = sha_pkg::big0(vars[0]) + maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      pad_step <= sha_pkg::PAD_NONE;
      fill <= '0;
      bit_length <= '0;
      hash <= {sha_pkg::INIT_HASH[7], sha_pkg::INIT_HASH[6], sha_pkg::INIT_HASH[5],
               sha_pkg::INIT_HASH[4], sha_pkg::INIT_HASH[3], sha_pkg::INIT_HASH[2],
               sha_pkg::INIT_HASH[1], sha_pkg::INIT_HASH[0]};
      round <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pad_step <= pad_step_next;
      out_valid <= out_valid_next;
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      if (take && has_byte) begin
        bit_length <= bit_length + sha_pkg::BYTE_BITS;
      end else if (len_put) begin
        bit_length <= {bit_length[55:0], 8'h00};
      end
      if (block_full) begin
        round <= '0;
      end else if (state == sha_pkg::ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (len_put || emit_load) begin
        cnt <= cnt + 3'd1;
      end
      if (state == sha_pkg::ST_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
      end else if (emit_load) begin
        // rotate out word 0 and refill with the initial hash behind it
        for (int i = 0; i < 7; i++) begin
          hash[i] <= hash[i+1];
        end
        hash[7] <= sha_pkg::INIT_HASH[cnt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      blk <= {blk[503:0], put_data};
    end else if (state == sha_pkg::ST_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
    if (block_full) begin
      vars <= hash;
    end else if (state == sha_pkg::ST_ROUND) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
    if (emit_load) begin
      digest_word <= hash[0];
      digest_last <= (cnt == sha_pkg::LAST_WORD);
    end
  end

endmodule

`default_nettype wire

// ===== src/sha_check.sv =====
`default_nettype none

module sha_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        end_of_message,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] digest_word,
  input wire logic        digest_last
);

  // closing a message always starts a compression or padding work
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_message |=> in_stall)
    else $error("core ready right after end of message");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(digest_last))
    else $error("stalled digest word changed");

  // a new digest cannot follow the last word at once
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && digest_last |=> !out_valid)
    else $error("digest word right after last word");

  // while taking bytes, only the final word of a digest may be pending
  a_idle_pending: assert property (@(posedge clk) disable iff (rst)
    !in_stall && out_valid |-> digest_last)
    else $error("core ready with unfinished digest");

endmodule

bind sha256_hash_core_top sha_check u_sha_check (.*);

`default_nettype wire
